>>> rtl/wsbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_pkg
// Shared widths, register indexes, the config struct and the tanh table for
// the windowed spectrum bin merge.
// ----------------------------------------------------------------------------
package wsbm_pkg;

	localparam int BIN_COUNT_DEF   = 4096;
	localparam int IDX_W           = 12;
	localparam int E_W             = 64;
	localparam int WGT_W           = 56;
	localparam int ACC_W           = 64;
	localparam int STEEP_W         = 16;
	localparam int WIN_BITS        = 30;
	localparam int WIN_W           = WIN_BITS + 1;
	localparam int DIV_CNT_W       = $clog2(WIN_BITS);
	localparam int TANH_TABLE_SIZE = 256;
	localparam int TANH_LOG2       = $clog2(TANH_TABLE_SIZE);
	localparam int TANH_IDX_W      = TANH_LOG2;
	localparam int TANH_ARG_FRAC   = 38;
	localparam int TANH_W          = 32;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	localparam logic [WIN_W-1:0] WIN_ONE  = WIN_W'(1) << WIN_BITS;
	localparam logic [WIN_W-1:0] WIN_HALF = WIN_W'(1) << (WIN_BITS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSOVER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HALVE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEEP     = 3'd7;

	typedef struct packed {
		logic [E_W-1:0]     lo;
		logic [E_W-1:0]     ex;
		logic [E_W-1:0]     hi;
		logic               first;
		logic               last;
		logic               zb;
		logic [STEEP_W-1:0] steep;
	} win_cfg_t;

	typedef logic [TANH_W-1:0] tanh_tab_t [TANH_TABLE_SIZE];

	localparam logic [63:0] Q58_ONE = 64'd1 << 58;

	// elaboration only: restoring divide
	function automatic logic [63:0] idiv_c(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_div_c(input logic [63:0] num,
		input logic [63:0] den, input int bits);
		logic [63:0] q;
		logic [63:0] r;
		logic        carry;
		q = '0;
		r = num;
		carry = 1'b0;
		if (den == 64'd0)
			return 64'd0;
		if (num >= den)
			return 64'd1 << bits;
		for (int i = 0; i < bits; i++) begin
			carry = r[63];
			r = r << 1;
			q = q << 1;
			if (carry || r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tanh_tab_t tanh_table();
		tanh_tab_t    t;
		logic [63:0]  term;
		logic [63:0]  g;
		logic [63:0]  p;
		logic [127:0] m;
		term = Q58_ONE;
		g = Q58_ONE;
		p = Q58_ONE;
		m = '0;
		for (int n = 1; n <= 30; n++) begin
			term = idiv_c(term * 64'd16, 64'(TANH_TABLE_SIZE) * 64'(n));
			if (n % 2 == 1)
				g = g - term;
			else
				g = g + term;
		end
		for (int k = 0; k < TANH_TABLE_SIZE; k++) begin
			t[k] = TANH_W'(frac_div_c(Q58_ONE - p, Q58_ONE + p, 31));
			m = 128'(p) * 128'(g);
			p = m[121:58];
		end
		return t;
	endfunction

	localparam tanh_tab_t TANH_TAB = tanh_table();

endpackage

>>> rtl/wsbm_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_item_if
// Input item channel: side, bin index, energy and weight.
// ----------------------------------------------------------------------------
interface wsbm_item_if;
	import wsbm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    side;
	logic [IDX_W-1:0]        bin_index;
	logic [E_W-1:0]          bin_energy;
	logic signed [WGT_W-1:0] bin_weight;

	modport source (output valid, side, bin_index, bin_energy, bin_weight, input ready);
	modport sink (input valid, side, bin_index, bin_energy, bin_weight, output ready);
endinterface

>>> rtl/wsbm_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_result_if
// Result channel: accumulator value and flags.
// ----------------------------------------------------------------------------
interface wsbm_result_if;
	import wsbm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] accumulated_weight;
	logic                    was_added;
	logic                    saturated;

	modport source (output valid, accumulated_weight, was_added, saturated, input ready);
	modport sink (input valid, accumulated_weight, was_added, saturated, output ready);
endinterface

>>> rtl/wsbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

>>> rtl/wsbm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_div
// Fractional divider, one quotient bit per cycle: floor(num/den * 2^30),
// one when num >= den, zero when den is zero.
// ----------------------------------------------------------------------------
module wsbm_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             num,
	input  logic [63:0]             den,
	output logic                    done,
	output logic [wsbm_pkg::WIN_W-1:0] quot
);
	import wsbm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [63:0]          rem_q;
	logic [63:0]          den_q;
	logic [WIN_W-1:0]     quot_q;
	logic [64:0]          rem2;
	logic                 ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (den == 64'd0 || num >= den)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(WIN_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			if (den == 64'd0)
				quot_q <= '0;
			else if (num >= den)
				quot_q <= WIN_ONE;
			else
				quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 64'(rem2 - {1'b0, den_q}) : rem2[63:0];
			quot_q <= {quot_q[WIN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

>>> rtl/wsbm_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsbm_window
// Window value in Q1.30 for one energy: step rules, linear ramp or
// normalized tanh shape from the interpolated table.
// ----------------------------------------------------------------------------
module wsbm_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wsbm_pkg::E_W-1:0]      energy,
	input  wsbm_pkg::win_cfg_t            cfg,
	output logic                          done,
	output logic [wsbm_pkg::WIN_W-1:0]    win
);
	import wsbm_pkg::*;

	localparam logic [3:0] W_IDLE = 4'd0;
	localparam logic [3:0] W_DIV1 = 4'd1;
	localparam logic [3:0] W_LKA  = 4'd2;
	localparam logic [3:0] W_LKM  = 4'd3;
	localparam logic [3:0] W_TARG = 4'd4;
	localparam logic [3:0] W_NUM  = 4'd5;
	localparam logic [3:0] W_DIV2 = 4'd6;

	logic [3:0]        state_q;
	logic              done_q;
	logic [WIN_W-1:0]  win_q;
	logic              rising_q;
	logic              tv_ph_q;
	logic [WIN_W-1:0]  x_q;
	logic [45:0]       arg_q;
	logic [TANH_W-1:0] a_q;
	logic [TANH_W-1:0] b_q;
	logic [15:0]       frac_q;
	logic [TANH_W-1:0] t1_q;
	logic [TANH_W-1:0] tv_q;

	logic              div_start;
	logic [63:0]       div_num;
	logic [63:0]       div_den;
	logic              div_done;
	logic [WIN_W-1:0]  div_q;
	logic              is_one;
	logic              rising;
	logic [63:0]       pos;
	logic [TANH_IDX_W-1:0] lk_idx;
	logic              lk_clip;
	logic [47:0]       lk_prod;
	logic [TANH_W-1:0] lk_t;
	logic [WIN_W-1:0]  mag_x;

	wsbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	assign is_one = (energy <= cfg.ex && cfg.last) || (energy >= cfg.ex && cfg.first) ||
		cfg.zb;
	assign rising = energy <= cfg.ex;

	assign pos     = (64'(arg_q) << TANH_LOG2) >> 3;
	assign lk_clip = pos[63:TANH_ARG_FRAC] >= 26'(TANH_TABLE_SIZE - 1);
	assign lk_idx  = pos[TANH_ARG_FRAC +: TANH_IDX_W];
	assign lk_prod = (b_q - a_q) * frac_q;
	assign lk_t    = a_q + lk_prod[47:16];
	assign mag_x   = x_q >= WIN_HALF ? x_q - WIN_HALF : WIN_HALF - x_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == W_IDLE && start && !is_one) begin
			div_start = 1'b1;
			div_num   = rising ? energy - cfg.lo : energy - cfg.ex;
			div_den   = rising ? cfg.ex - cfg.lo : cfg.hi - cfg.ex;
		end else if (state_q == W_NUM) begin
			div_start = 1'b1;
			div_num   = x_q >= WIN_HALF ? 64'(t1_q) + 64'(tv_q) : 64'(t1_q) - 64'(tv_q);
			div_den   = 64'(t1_q) << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
			tv_ph_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						if (is_one)
							done_q <= 1'b1;
						else
							state_q <= W_DIV1;
					end
				end
				W_DIV1: begin
					if (div_done) begin
						if (cfg.steep == '0) begin
							done_q  <= 1'b1;
							state_q <= W_IDLE;
						end else begin
							tv_ph_q <= 1'b0;
							state_q <= W_LKA;
						end
					end
				end
				W_LKA: state_q <= W_LKM;
				W_LKM: begin
					if (!tv_ph_q) begin
						if (lk_t == '0) begin
							done_q  <= 1'b1;
							state_q <= W_IDLE;
						end else begin
							state_q <= W_TARG;
						end
					end else begin
						state_q <= W_NUM;
					end
				end
				W_TARG: begin
					tv_ph_q <= 1'b1;
					state_q <= W_LKA;
				end
				W_NUM: state_q <= W_DIV2;
				W_DIV2: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				rising_q <= rising;
				win_q    <= WIN_ONE;
			end
			W_DIV1: begin
				if (div_done) begin
					x_q   <= div_q;
					win_q <= rising_q ? div_q : WIN_ONE - div_q;
					arg_q <= 46'(cfg.steep) << (WIN_BITS - 1);
				end
			end
			W_LKA: begin
				if (lk_clip) begin
					a_q    <= TANH_TAB[TANH_TABLE_SIZE-1];
					b_q    <= TANH_TAB[TANH_TABLE_SIZE-1];
					frac_q <= '0;
				end else begin
					a_q    <= TANH_TAB[lk_idx];
					b_q    <= TANH_TAB[lk_idx + 1'b1];
					frac_q <= pos[37:22];
				end
			end
			W_LKM: begin
				if (!tv_ph_q)
					t1_q <= lk_t;
				else
					tv_q <= lk_t > t1_q ? t1_q : lk_t;
			end
			W_TARG: arg_q <= 46'(cfg.steep * mag_x[WIN_BITS-1:0]);
			W_DIV2: begin
				if (div_done)
					win_q <= rising_q ? div_q : WIN_ONE - div_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign win  = win_q;
endmodule

>>> rtl/windowed_spectrum_bin_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_spectrum_bin_merge
// Merges windowed spectral weights into per-side, per-bin accumulators.
// ----------------------------------------------------------------------------
// Items arrive on a valid/ready channel (side, bin, energy, weight); each
// transfer yields one result (accumulator after the item, added and saturated
// flags) on the result channel. Window and flag registers are written through
// wr_en/wr_index/wr_data; the user must do so only while the block is idle,
// which the block itself does not enforce. The accumulators live in one RAM of
// 2*BIN_COUNT words, read-modify-written once for each item that passes the
// gate with a bin index below BIN_COUNT. One item is in flight at a time. An
// item that fails the gate or has an out-of-range bin skips the window, a
// window of one skips the divider, the linear ramp uses the bit-serial divider
// (one bit a cycle) and the tanh shape adds the table interpolation steps.
// After reset a clearing pass zeroes every RAM word with items ready held low.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in its last step until the earlier result is taken.
// ----------------------------------------------------------------------------
module windowed_spectrum_bin_merge #(
	parameter int BIN_COUNT = wsbm_pkg::BIN_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	wsbm_item_if.sink                        items,
	wsbm_result_if.source                    results,
	input  logic                             wr_en,
	input  logic [wsbm_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [wsbm_pkg::CFG_DATA_W-1:0]  wr_data
);
	import wsbm_pkg::*;

	localparam int MEM_DEPTH = 2 * BIN_COUNT;
	localparam int AW        = $clog2(MEM_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_WIN  = 3'd2;
	localparam logic [2:0] ST_MULH = 3'd3;
	localparam logic [2:0] ST_MULL = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	win_cfg_t         cfg_q;
	logic             halve_q;
	logic [2:0]       state_q;
	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;
	logic [AW-1:0]    addr_q;
	logic [E_W-1:0]   e_q;
	logic             neg_q;
	logic [WGT_W-1:0] mag_q;
	logic             gate_q;
	logic             ign_q;
	logic [ACC_W-1:0] acc_q;
	logic [WIN_W-1:0] w_q;
	logic [63:0]      ph_q;
	logic [WIN_W-1:0] pl_q;
	logic             out_valid_q;
	logic [ACC_W-1:0] out_acc_q;
	logic             out_added_q;
	logic             out_sat_q;

	logic             in_xfer;
	logic             out_free;
	logic             finish;
	logic [WGT_W-1:0] wraw;
	logic [WGT_W-1:0] mag;
	logic [E_W-1:0]   lo;
	logic             gate;
	logic             ign;
	logic [AW-1:0]    addr;
	logic [63:0]      prod;
	logic [ACC_W-1:0] sum;
	logic             sat;
	logic [60:0]      pl_full;
	logic             win_start;
	logic             win_done;
	logic [WIN_W-1:0] win_val;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ACC_W-1:0] ram_wdata;
	logic [ACC_W-1:0] ram_rdata;

	assign items.ready = state_q == ST_IDLE && !clr_q;
	assign in_xfer     = items.valid && items.ready;
	assign out_free    = !out_valid_q || results.ready;
	assign finish      = state_q == ST_DONE && out_free;

	assign wraw = items.bin_weight;
	assign mag  = wraw[WGT_W-1] ? WGT_W'(~wraw + 1'b1) : wraw;
	assign lo   = cfg_q.zb ? '0 : cfg_q.lo;
	assign gate = items.bin_energy > lo && (cfg_q.zb || items.bin_energy < cfg_q.hi) &&
		mag != '0;
	assign ign  = {20'd0, items.bin_index} >= 32'(BIN_COUNT);
	assign addr = items.side ? AW'(BIN_COUNT) + AW'(items.bin_index) : AW'(items.bin_index);

	assign pl_full = mag_q[WIN_BITS-1:0] * w_q;

	always_comb begin
		prod = ph_q + 64'(pl_q);
		if (halve_q)
			prod = prod >> 1;
		sat = 1'b0;
		if (neg_q) begin
			sum = acc_q - prod;
			if (acc_q[ACC_W-1] && !sum[ACC_W-1]) begin
				sum = {1'b1, {(ACC_W-1){1'b0}}};
				sat = 1'b1;
			end
		end else begin
			sum = acc_q + prod;
			if (!acc_q[ACC_W-1] && sum[ACC_W-1]) begin
				sum = {1'b0, {(ACC_W-1){1'b1}}};
				sat = 1'b1;
			end
		end
	end

	assign win_start = state_q == ST_READ && gate_q && !ign_q;

	wsbm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (win_start),
		.energy (e_q),
		.cfg    (cfg_q),
		.done   (win_done),
		.win    (win_val)
	);

	assign ram_we    = clr_q || (finish && gate_q && !ign_q);
	assign ram_waddr = clr_q ? clr_addr_q : addr_q;
	assign ram_wdata = clr_q ? '0 : sum;

	wsbm_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_xfer && !ign),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			halve_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LOW_EDGE:  cfg_q.lo    <= wr_data;
				REG_CROSSOVER: cfg_q.ex    <= wr_data;
				REG_HIGH_EDGE: cfg_q.hi    <= wr_data;
				REG_FIRST:     cfg_q.first <= wr_data[0];
				REG_LAST:      cfg_q.last  <= wr_data[0];
				REG_ZERO_BW:   cfg_q.zb    <= wr_data[0];
				REG_HALVE:     halve_q     <= wr_data[0];
				REG_STEEP:     cfg_q.steep <= wr_data[STEEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MEM_DEPTH - 1))
					clr_q <= 1'b0;
			end
			if (results.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_READ;
				ST_READ: state_q <= (gate_q && !ign_q) ? ST_WIN : ST_DONE;
				ST_WIN:  if (win_done) state_q <= ST_MULH;
				ST_MULH: state_q <= ST_MULL;
				ST_MULL: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			addr_q <= addr;
			e_q    <= items.bin_energy;
			neg_q  <= wraw[WGT_W-1];
			mag_q  <= mag;
			gate_q <= gate;
			ign_q  <= ign;
		end
		if (state_q == ST_READ)
			acc_q <= ign_q ? '0 : ram_rdata;
		if (state_q == ST_WIN && win_done)
			w_q <= win_val;
		if (state_q == ST_MULH)
			ph_q <= 64'(mag_q[WGT_W-1:WIN_BITS] * w_q);
		if (state_q == ST_MULL)
			pl_q <= pl_full[60:WIN_BITS];
		if (finish) begin
			if (gate_q && !ign_q) begin
				out_acc_q   <= sum;
				out_added_q <= 1'b1;
				out_sat_q   <= sat;
			end else begin
				out_acc_q   <= acc_q;
				out_added_q <= 1'b0;
				out_sat_q   <= 1'b0;
			end
		end
	end

	assign results.valid              = out_valid_q;
	assign results.accumulated_weight = out_acc_q;
	assign results.was_added          = out_added_q;
	assign results.saturated          = out_sat_q;
endmodule
